FILE: hw/rtl/round_robin_slice_scheduler_core_defines.svh
// Assertion macros shared by the scheduler RTL.
// Used by round_robin_slice_scheduler_core.sv; expects clk and rst_n in scope.
`ifndef ROUND_ROBIN_SLICE_SCHEDULER_CORE_DEFINES_SVH
`define ROUND_ROBIN_SLICE_SCHEDULER_CORE_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define RRSS_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define RRSS_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

// Condition must hold in every cycle out of reset.
`define RRSS_ASSERT_ALWAYS(label, cond, msg) \
    `RRSS_ASSERT_SAME(label, 1'b1, cond, msg)

`endif

FILE: hw/rtl/rrss_pkg.sv
// Shared types and constants of the round-robin slice scheduler.
// No dependencies; used by rrss_alu and the top level.
package rrss_pkg;

    localparam int LEN_W  = 16;   // job_length, ran_for, time_slice
    localparam int ID_W   = 6;    // job_id field
    localparam int TIME_W = 32;   // elapsed-time fields

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_SLICE = 1'b1;

    typedef enum logic [1:0] {
        ALU_MIN       = 2'd0,
        ALU_ADD       = 2'd1,
        ALU_ADD_SAT   = 2'd2,
        ALU_SUB_CLAMP = 2'd3
    } alu_op_t;

endpackage

FILE: hw/rtl/round_robin_slice_scheduler_core.sv
// Round-robin time-slice scheduler: sequencer, job counters and result registers.
// Depends on rrss_pkg, rrss_alu, rrss_table and the assertion macro header.
//
// An item is taken when start is high and busy is low; its result appears on
// the result ports for one cycle with done high, and the receiver cannot
// stall it. An add item, or a slice item with no active job, passes through a
// single state before its result. Otherwise the search visits 1 to MAX_JOBS
// table entries from the current rotation point: each entry is read in S_RD
// from the job table, whose read data is registered, and checked in S_CHK; the
// accounting then runs five steps through one shared 32-bit adder before S_WB.
// The table needs no clearing after reset: entries at or above the job count
// are treated as inactive. time_slice is written through cfg_valid/cfg_data;
// the user must write it only while the block is idle; the block does not enforce this.
module round_robin_slice_scheduler_core #(
    parameter int MAX_JOBS = 64,
    parameter int LEN_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         op,
    input  logic [rrss_pkg::LEN_W-1:0]   job_length,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rrss_pkg::LEN_W-1:0]   cfg_data,
    output logic                         done,
    output logic [1:0]                   status,
    output logic [rrss_pkg::ID_W-1:0]    job_id,
    output logic [rrss_pkg::LEN_W-1:0]   ran_for,
    output logic                         finished,
    output logic [rrss_pkg::TIME_W-1:0]  turnaround,
    output logic [rrss_pkg::TIME_W-1:0]  wait_time,
    output logic [rrss_pkg::TIME_W-1:0]  response_time,
    output logic                         all_done
);
    import rrss_pkg::*;

    `include "round_robin_slice_scheduler_core_defines.svh"

    localparam int IDX_W  = $clog2(MAX_JOBS);
    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int RT_LSB = LEN_BITS;
    localparam int FR_LSB = 2 * LEN_BITS;
    localparam int ST_BIT = 2 * LEN_BITS + TIME_W;
    localparam int AC_BIT = ST_BIT + 1;
    localparam int WORD_W = AC_BIT + 1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_ADD   = 11'b000_0000_0010,
        S_EMPTY = 11'b000_0000_0100,
        S_RD    = 11'b000_0000_1000,
        S_CHK   = 11'b000_0001_0000,
        S_MIN   = 11'b000_0010_0000,
        S_ELAP  = 11'b000_0100_0000,
        S_RUN   = 11'b000_1000_0000,
        S_WAIT  = 11'b001_0000_0000,
        S_REM   = 11'b010_0000_0000,
        S_WB    = 11'b100_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    ts_reg, ts_next;
    logic [CNT_W-1:0]    job_count_reg, job_count_next;
    logic [CNT_W-1:0]    active_count_reg, active_count_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                done_reg, done_next;

    logic [LEN_BITS-1:0] len_reg, len_next;
    logic [LEN_W-1:0]    w_reg, w_next;
    logic [LEN_BITS-1:0] rt_reg, rt_next;
    logic [TIME_W-1:0]   wait_reg, wait_next;
    logic [LEN_BITS-1:0] rem_reg, rem_next;

    logic [1:0]          status_reg, status_next;
    logic [ID_W-1:0]     job_id_reg, job_id_next;
    logic [LEN_W-1:0]    ran_for_reg, ran_for_next;
    logic                finished_reg, finished_next;
    logic [TIME_W-1:0]   turn_reg, turn_next;
    logic [TIME_W-1:0]   wait_out_reg, wait_out_next;
    logic [TIME_W-1:0]   resp_reg, resp_next;
    logic                all_done_reg, all_done_next;

    logic                accept;
    alu_op_t             alu_op;
    logic [TIME_W-1:0]   alu_a, alu_b, alu_y;
    logic                tbl_wr_en;
    logic [IDX_W-1:0]    tbl_wr_addr;
    logic [WORD_W-1:0]   tbl_wr_data;
    logic [WORD_W-1:0]   tbl_rd_data;

    logic [LEN_BITS-1:0] e_rem, e_rt;
    logic [TIME_W-1:0]   e_fr;
    logic                e_started, e_active;
    logic                entry_live;
    logic [IDX_W-1:0]    idx_inc;
    logic                job_fin;
    logic [CNT_W-1:0]    active_dec;
    logic [TIME_W-1:0]   fr_new;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign e_rem     = tbl_rd_data[LEN_BITS-1:0];
    assign e_rt      = tbl_rd_data[RT_LSB +: LEN_BITS];
    assign e_fr      = tbl_rd_data[FR_LSB +: TIME_W];
    assign e_started = tbl_rd_data[ST_BIT];
    assign e_active  = tbl_rd_data[AC_BIT];

    // Entries at or above the job count were never written and count as inactive.
    assign entry_live = (CNT_W'(idx_reg) < job_count_reg) && e_active;
    assign idx_inc    = (idx_reg == IDX_W'(MAX_JOBS - 1)) ? '0 : idx_reg + 1'b1;
    assign job_fin    = (rem_reg == '0);
    assign active_dec = (job_fin && (active_count_reg != '0)) ?
                        active_count_reg - 1'b1 : active_count_reg;
    assign fr_new     = e_started ? e_fr : wait_reg;

    rrss_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    rrss_table #(
        .DEPTH  (MAX_JOBS),
        .WORD_W (WORD_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (idx_reg),
        .rd_data (tbl_rd_data)
    );

    always_comb
    begin
        case (state_reg)
            S_MIN:
            begin
                alu_op = ALU_MIN;
                alu_a  = TIME_W'(e_rem);
                alu_b  = TIME_W'(ts_reg);
            end
            S_ELAP:
            begin
                alu_op = ALU_ADD_SAT;
                alu_a  = elapsed_reg;
                alu_b  = TIME_W'(w_reg);
            end
            S_RUN:
            begin
                alu_op = ALU_ADD;
                alu_a  = TIME_W'(e_rt);
                alu_b  = TIME_W'(w_reg);
            end
            S_WAIT:
            begin
                alu_op = ALU_SUB_CLAMP;
                alu_a  = elapsed_reg;
                alu_b  = TIME_W'(rt_reg);
            end
            S_REM:
            begin
                alu_op = ALU_SUB_CLAMP;
                alu_a  = TIME_W'(e_rem);
                alu_b  = TIME_W'(w_reg);
            end
            default:
            begin
                alu_op = ALU_ADD;
                alu_a  = '0;
                alu_b  = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        ts_next           = ts_reg;
        job_count_next    = job_count_reg;
        active_count_next = active_count_reg;
        cur_next          = cur_reg;
        elapsed_next      = elapsed_reg;
        idx_next          = idx_reg;
        done_next         = 1'b0;
        len_next          = len_reg;
        w_next            = w_reg;
        rt_next           = rt_reg;
        wait_next         = wait_reg;
        rem_next          = rem_reg;
        status_next       = status_reg;
        job_id_next       = job_id_reg;
        ran_for_next      = ran_for_reg;
        finished_next     = finished_reg;
        turn_next         = turn_reg;
        wait_out_next     = wait_out_reg;
        resp_next         = resp_reg;
        all_done_next     = all_done_reg;
        tbl_wr_en         = 1'b0;
        tbl_wr_addr       = idx_reg;
        tbl_wr_data       = '0;

        if (cfg_valid && cfg_ready)
        begin
            ts_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    len_next = LEN_BITS'(job_length);
                    idx_next = cur_reg;
                    if (op == OP_ADD)
                    begin
                        state_next = S_ADD;
                    end
                    else if (active_count_reg == '0)
                    begin
                        state_next = S_EMPTY;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_ADD:
            begin
                ran_for_next  = '0;
                finished_next = 1'b0;
                turn_next     = '0;
                wait_out_next = '0;
                resp_next     = '0;
                if (job_count_reg >= CNT_W'(MAX_JOBS))
                begin
                    status_next   = STATUS_FULL;
                    job_id_next   = '0;
                    all_done_next = (active_count_reg == '0);
                end
                else
                begin
                    tbl_wr_en         = 1'b1;
                    tbl_wr_addr       = IDX_W'(job_count_reg);
                    tbl_wr_data       = '0;
                    tbl_wr_data[LEN_BITS-1:0] = len_reg;
                    tbl_wr_data[AC_BIT]       = 1'b1;
                    job_count_next    = job_count_reg + 1'b1;
                    active_count_next = active_count_reg + 1'b1;
                    status_next       = STATUS_DONE;
                    job_id_next       = ID_W'(job_count_reg);
                    all_done_next     = 1'b0;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_EMPTY:
            begin
                status_next   = STATUS_EMPTY;
                job_id_next   = '0;
                ran_for_next  = '0;
                finished_next = 1'b0;
                turn_next     = '0;
                wait_out_next = '0;
                resp_next     = '0;
                all_done_next = 1'b1;
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                // An active entry exists whenever the search starts, so it ends.
                if (entry_live)
                begin
                    state_next = S_MIN;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_RD;
                end
            end
            S_MIN:
            begin
                w_next     = LEN_W'(alu_y);
                state_next = S_ELAP;
            end
            S_ELAP:
            begin
                elapsed_next = alu_y;
                state_next   = S_RUN;
            end
            S_RUN:
            begin
                rt_next    = LEN_BITS'(alu_y);
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                wait_next  = alu_y;
                state_next = S_REM;
            end
            S_REM:
            begin
                rem_next   = LEN_BITS'(alu_y);
                state_next = S_WB;
            end
            S_WB:
            begin
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = idx_reg;
                tbl_wr_data = {!job_fin, 1'b1, fr_new, rt_reg, rem_reg};
                active_count_next = active_dec;
                cur_next      = idx_inc;
                status_next   = STATUS_DONE;
                job_id_next   = ID_W'(idx_reg);
                ran_for_next  = w_reg;
                finished_next = job_fin;
                turn_next     = elapsed_reg;
                wait_out_next = wait_reg;
                resp_next     = fr_new;
                all_done_next = (active_dec == '0);
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ts_reg           <= LEN_W'(4);
            job_count_reg    <= '0;
            active_count_reg <= '0;
            cur_reg          <= '0;
            elapsed_reg      <= '0;
            idx_reg          <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ts_reg           <= ts_next;
            job_count_reg    <= job_count_next;
            active_count_reg <= active_count_next;
            cur_reg          <= cur_next;
            elapsed_reg      <= elapsed_next;
            idx_reg          <= idx_next;
            done_reg         <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        w_reg        <= w_next;
        rt_reg       <= rt_next;
        wait_reg     <= wait_next;
        rem_reg      <= rem_next;
        status_reg   <= status_next;
        job_id_reg   <= job_id_next;
        ran_for_reg  <= ran_for_next;
        finished_reg <= finished_next;
        turn_reg     <= turn_next;
        wait_out_reg <= wait_out_next;
        resp_reg     <= resp_next;
        all_done_reg <= all_done_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign job_id        = job_id_reg;
    assign ran_for       = ran_for_reg;
    assign finished      = finished_reg;
    assign turnaround    = turn_reg;
    assign wait_time     = wait_out_reg;
    assign response_time = resp_reg;
    assign all_done      = all_done_reg;

    `RRSS_ASSERT_ALWAYS(a_active_le_jobs, active_count_reg <= job_count_reg, "too many active jobs")
    `RRSS_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item did not make the block busy")
    `RRSS_ASSERT_SAME(a_done_idle, done_reg, state_reg == S_IDLE, "result shown while busy")
    `RRSS_ASSERT_SAME(a_fell_done, $fell(busy), done_reg, "item finished without a result")
    `RRSS_ASSERT_SAME(a_search_live, state_reg == S_CHK, active_count_reg != '0, "empty search")

endmodule

FILE: hw/rtl/rrss_alu.sv
// Shared 32-bit add/subtract unit with min, saturate and clamp modes.
// Depends on rrss_pkg.
module rrss_alu (
    input  rrss_pkg::alu_op_t          op,
    input  logic [rrss_pkg::TIME_W-1:0] a,
    input  logic [rrss_pkg::TIME_W-1:0] b,
    output logic [rrss_pkg::TIME_W-1:0] y
);
    import rrss_pkg::*;

    logic              sub;
    logic [TIME_W-1:0] b_eff;
    logic [TIME_W:0]   sum;

    // One adder; for subtraction the top bit is set when there is no borrow.
    assign sub   = !(op inside {ALU_ADD, ALU_ADD_SAT});
    assign b_eff = sub ? ~b : b;
    assign sum   = {1'b0, a} + {1'b0, b_eff} + (TIME_W + 1)'(sub);

    always_comb
    begin
        case (op)
            ALU_MIN:       y = sum[TIME_W] ? b : a;
            ALU_ADD:       y = sum[TIME_W-1:0];
            ALU_ADD_SAT:   y = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
            ALU_SUB_CLAMP: y = sum[TIME_W] ? sum[TIME_W-1:0] : '0;
            default:       y = '0;
        endcase
    end

endmodule

FILE: hw/rtl/rrss_table.sv
// Per-job table: one write port, one read port with registered read data.
// No dependencies.
module rrss_table #(
    parameter int DEPTH  = 64,
    parameter int WORD_W = 66
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WORD_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WORD_W-1:0]        rd_data
);
    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
